// ===== sv/mrhf_pkg.sv =====
// mrhf_pkg: types, codes and constants for the mesh header filter
// used by mrhf_seen_cell, mrhf_decide and mesh_rx_header_filter_dedup
`default_nettype none

package mrhf_pkg;

	localparam int SEEN_DEPTH_DEF   = 16;
	localparam int ENC_FLAG_BIT_DEF = 7;
	localparam logic [7:0] HEADER_BYTES = 8'd5;
	localparam logic [1:0] ROLE_ENDPOINT = 2'd0;

	typedef enum logic [1:0] {
		CFG_ENABLED  = 2'd0,
		CFG_OWN_NODE = 2'd1,
		CFG_ROLE     = 2'd2,
		CFG_SECURITY = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		V_ACCEPT    = 3'd0,
		V_DISABLED  = 3'd1,
		V_SHORT     = 3'd2,
		V_ENC_BCAST = 3'd3,
		V_TTL       = 3'd4,
		V_DUP       = 3'd5
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_DECIDE
	} state_t;

	typedef logic [15:0] pair_t;

	typedef struct packed {
		logic       enabled;
		logic [7:0] own_node;
		logic [1:0] role;
		logic       security;
	} cfg_t;

	typedef struct packed {
		logic [7:0] seq_number;
		logic [7:0] origin_node;
		logic [7:0] dest_node;
		logic [7:0] ctrl_ttl;
		logic [7:0] packet_length;
	} hdr_t;

	typedef struct packed {
		verdict_t   verdict;
		logic       relay_now;
		logic [7:0] relay_flags_ttl;
		logic [7:0] relay_stamp_node;
		logic       deliver_local;
		logic [7:0] payload_length;
		logic       needs_decrypt;
		logic [3:0] delivered_ttl;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/mesh_rx_header_filter_dedup.sv =====
// mesh_rx_header_filter_dedup: receive header filter with duplicate suppression
// a chain of mrhf_seen_cell entries holds recent (origin, sequence) pairs
// depends on mrhf_pkg, mrhf_seen_cell, mrhf_decide
//
// usage:
//   input channel in_valid / in_stall carries one received header per item;
//   output channel out_valid / out_stall carries one verdict item per header.
//   configuration is written through cfg_we / cfg_index / cfg_data, which the
//   user must do only while idle; the block itself does not enforce this.
// an accepted header is registered, its key is compared in every cell and the
//   hit registered, then, once the output is free, the decide step registers the
//   result; no new header is taken until the last one leaves the decide step.
// headers with an accept verdict shift into the head of the cell chain; the oldest
//   pair falls off the tail, which matches ring-order replacement.
// reset clears every cell to zero, so an all-zero pair reads as a duplicate,
//   and loads the register defaults (disabled, own node 1, endpoint role).
// when the receiver stalls, the result holds; one more item can be accepted
//   and compared, and it waits in the decide step until the output frees.
`default_nettype none

module mesh_rx_header_filter_dedup
	import mrhf_pkg::*;
#(
	parameter int SEEN_DEPTH   = SEEN_DEPTH_DEF,
	parameter int ENC_FLAG_BIT = ENC_FLAG_BIT_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,

	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] seq_number,
	input  wire logic [7:0] origin_node,
	input  wire logic [7:0] dest_node,
	input  wire logic [7:0] ctrl_ttl,
	input  wire logic [7:0] last_relay_node,
	input  wire logic [7:0] packet_length,

	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      verdict,
	output logic            relay_now,
	output logic [7:0]      relay_flags_ttl,
	output logic [7:0]      relay_stamp_node,
	output logic            deliver_local,
	output logic [7:0]      payload_length,
	output logic            needs_decrypt,
	output logic [3:0]      delivered_ttl
);

	cfg_t    cfg_q;
	hdr_t    hdr_q;
	state_t  state_q, state_d;
	result_t res_d, res_q;
	logic    out_valid_q;
	logic    in_accept;
	logic    commit;
	logic    store;
	logic    any_hit;
	pair_t   key;
	pair_t   chain [SEEN_DEPTH+1];
	logic [SEEN_DEPTH-1:0] hit_vec;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled  <= 1'b0;
			cfg_q.own_node <= 8'd1;
			cfg_q.role     <= ROLE_ENDPOINT;
			cfg_q.security <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ENABLED:  cfg_q.enabled  <= cfg_data[0];
				CFG_OWN_NODE: cfg_q.own_node <= cfg_data;
				CFG_ROLE:     cfg_q.role     <= cfg_data[1:0];
				CFG_SECURITY: cfg_q.security <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// header capture
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			hdr_q.seq_number    <= seq_number;
			hdr_q.origin_node   <= origin_node;
			hdr_q.dest_node     <= dest_node;
			hdr_q.ctrl_ttl      <= ctrl_ttl;
			hdr_q.packet_length <= packet_length;
		end
	end

	assign key = {hdr_q.origin_node, hdr_q.seq_number};

	// seen-pair chain
	assign chain[0] = key;

	for (genvar i = 0; i < SEEN_DEPTH; i++) begin : g_cell
		mrhf_seen_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (store),
			.pair_in  (chain[i]),
			.key      (key),
			.pair_out (chain[i+1]),
			.hit      (hit_vec[i])
		);
	end

	assign any_hit = |hit_vec;

	mrhf_decide #(
		.ENC_FLAG_BIT (ENC_FLAG_BIT)
	) u_decide (
		.hdr      (hdr_q),
		.cfg      (cfg_q),
		.seen_hit (any_hit),
		.res      (res_d)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_CMP;
			ST_CMP:    state_d = ST_DECIDE;
			ST_DECIDE: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		commit   = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_CMP:    in_stall = 1'b1;
			ST_DECIDE: commit   = !out_valid_q || !out_stall;
			default:   in_stall = 1'b1;
		endcase
	end

	assign store = commit && (res_d.verdict == V_ACCEPT);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign verdict          = res_q.verdict;
	assign relay_now        = res_q.relay_now;
	assign relay_flags_ttl  = res_q.relay_flags_ttl;
	assign relay_stamp_node = res_q.relay_stamp_node;
	assign deliver_local    = res_q.deliver_local;
	assign payload_length   = res_q.payload_length;
	assign needs_decrypt    = res_q.needs_decrypt;
	assign delivered_ttl    = res_q.delivered_ttl;

	// checks
	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_CMP)
		else $error("accepted item did not enter compare");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("decided item not presented");

	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.verdict != V_ACCEPT |-> !relay_now && !deliver_local)
		else $error("rejected item relays or delivers");

	a_store_head: assert property (@(posedge clk) disable iff (!arst_n)
		store |=> chain[1] == $past(key))
		else $error("accepted pair not at head of chain");

endmodule

`default_nettype wire

// ===== sv/mrhf_seen_cell.sv =====
// mrhf_seen_cell: one entry of the seen-pair chain with its own compare
// depends on mrhf_pkg
`default_nettype none

module mrhf_seen_cell
	import mrhf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  shift_en,
	input  wire pair_t pair_in,
	input  wire pair_t key,
	output pair_t      pair_out,
	output logic       hit
);

	pair_t pair_q;
	logic  hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
			hit_q  <= 1'b0;
		end else begin
			hit_q <= (pair_q == key);
			if (shift_en) begin
				pair_q <= pair_in;
			end
		end
	end

	assign pair_out = pair_q;
	assign hit      = hit_q;

endmodule

`default_nettype wire

// ===== sv/mrhf_decide.sv =====
// mrhf_decide: verdict priority and relay / delivery fields for one header
// depends on mrhf_pkg
`default_nettype none

module mrhf_decide
	import mrhf_pkg::*;
#(
	parameter int ENC_FLAG_BIT = ENC_FLAG_BIT_DEF
) (
	input  wire hdr_t  hdr,
	input  wire cfg_t  cfg,
	input  wire logic  seen_hit,
	output result_t    res
);

	logic [3:0] ttl;
	logic       encrypted;
	logic       relay;
	logic       deliver;
	verdict_t   v;

	assign ttl       = hdr.ctrl_ttl[3:0];
	assign encrypted = hdr.ctrl_ttl[ENC_FLAG_BIT];

	always_comb begin
		if (!cfg.enabled) begin
			v = V_DISABLED;
		end else if (hdr.packet_length < HEADER_BYTES) begin
			v = V_SHORT;
		end else if (hdr.dest_node == 8'd0 && encrypted) begin
			v = V_ENC_BCAST;
		end else if (ttl == 4'd0) begin
			v = V_TTL;
		end else if (seen_hit) begin
			v = V_DUP;
		end else begin
			v = V_ACCEPT;
		end
	end

	assign relay   = (v == V_ACCEPT) && (hdr.dest_node != cfg.own_node)
		&& (cfg.role != ROLE_ENDPOINT);
	assign deliver = (v == V_ACCEPT)
		&& (hdr.dest_node == cfg.own_node || hdr.dest_node == 8'd0);

	always_comb begin
		res                  = '0;
		res.verdict          = v;
		res.relay_now        = relay;
		res.deliver_local    = deliver;
		if (relay) begin
			res.relay_flags_ttl  = {hdr.ctrl_ttl[7:4], ttl - 4'd1};
			res.relay_stamp_node = cfg.own_node;
		end
		if (deliver) begin
			res.payload_length = hdr.packet_length - HEADER_BYTES;
			res.needs_decrypt  = encrypted && cfg.security;
			res.delivered_ttl  = ttl;
		end
	end

endmodule

`default_nettype wire
